// ===== src/greedy_note_dispenser_top_defines.svh =====
// assertion macros shared by the dispenser rtl
`ifndef GREEDY_NOTE_DISPENSER_TOP_DEFINES_SVH
`define GREEDY_NOTE_DISPENSER_TOP_DEFINES_SVH

// same-cycle implication, checked on every rising edge outside reset
`define GND_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GND_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/gnd_pkg.sv =====
`default_nettype none

package gnd_pkg;

  localparam int AMOUNT_W   = 31;
  localparam int SLOT_W     = 3;
  localparam int DENOM_MAX  = 7;
  localparam int DIV_CNT_W  = $clog2(AMOUNT_W);

  localparam logic [SLOT_W-1:0] CFG_DENOM_COUNT = 3'd0;
  localparam logic [SLOT_W-1:0] CFG_DENOM_BASE  = 3'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_WAIT,
    ST_EMIT
  } gnd_state_e;

  // divider status towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } gnd_div_stat_t;

endpackage

`default_nettype wire

// ===== src/gnd_cfg_regs.sv =====
`default_nettype none

module gnd_cfg_regs #(
  parameter int MAX_DENOMS = gnd_pkg::DENOM_MAX
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [gnd_pkg::SLOT_W-1:0]   cfg_index_i,
  input  wire logic [gnd_pkg::AMOUNT_W-1:0] cfg_data_i,
  input  wire logic [gnd_pkg::SLOT_W-1:0]   slot_i,
  output logic      [gnd_pkg::SLOT_W-1:0]   used_o,
  output logic      [gnd_pkg::AMOUNT_W-1:0] denom_o
);

  logic [gnd_pkg::SLOT_W-1:0]   count_q;
  logic [gnd_pkg::AMOUNT_W-1:0] denom_q [MAX_DENOMS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= gnd_pkg::SLOT_W'(1);
      for (int k = 0; k < MAX_DENOMS; k++) begin
        denom_q[k] <= (k == 0) ? gnd_pkg::AMOUNT_W'(1) : '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_index_i == gnd_pkg::CFG_DENOM_COUNT) begin
        count_q <= cfg_data_i[gnd_pkg::SLOT_W-1:0];
      end
      for (int k = 0; k < MAX_DENOMS; k++) begin
        if (cfg_index_i == gnd_pkg::CFG_DENOM_BASE + gnd_pkg::SLOT_W'(k)) begin
          denom_q[k] <= cfg_data_i;
        end
      end
    end
  end

  // slot count saturates at the table depth
  assign used_o = (count_q > gnd_pkg::SLOT_W'(MAX_DENOMS)) ?
                  gnd_pkg::SLOT_W'(MAX_DENOMS) : count_q;

  always_comb begin
    denom_o = '0;
    for (int k = 0; k < MAX_DENOMS; k++) begin
      if (slot_i == gnd_pkg::SLOT_W'(k)) begin
        denom_o = denom_q[k];
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/gnd_divider.sv =====
`default_nettype none

module gnd_divider (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [gnd_pkg::AMOUNT_W-1:0] dividend_i,
  input  wire logic [gnd_pkg::AMOUNT_W-1:0] divisor_i,
  output gnd_pkg::gnd_div_stat_t            stat_o,
  output logic      [gnd_pkg::AMOUNT_W-1:0] quot_o,
  output logic      [gnd_pkg::AMOUNT_W-1:0] rem_o
);

  localparam int W = gnd_pkg::AMOUNT_W;

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [gnd_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [W-1:0]                  quot_q, quot_d;
  logic [W-1:0]                  rem_q, rem_d;
  logic [W-1:0]                  div_q, div_d;
  logic [W:0]                    trial;
  logic [W:0]                    diff;
  logic                          fits;

  // one restoring step per cycle, msb first
  always_comb begin
    trial  = {rem_q, quot_q[W-1]};
    diff   = trial - {1'b0, div_q};
    fits   = (trial >= {1'b0, div_q});
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = gnd_pkg::DIV_CNT_W'(W - 1);
      quot_d = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      rem_d  = fits ? diff[W-1:0] : trial[W-1:0];
      quot_d = {quot_q[W-2:0], fits};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quot_q;
  assign rem_o       = rem_q;

endmodule

`default_nettype wire

// ===== src/greedy_note_dispenser_top.sv =====
// sequence: an amount is accepted, then each slot in use is worked in turn
// (a nonzero note value: start, 31 restoring steps on the shared divider, capture, emit;
// a zero note value: start, emit), plus any output stall
// throughput: one amount at a time, the next is taken once the slot 0 result is transferred
// reset: asynchronous active low, slot count 1, slot 0 value 1, other values 0
`default_nettype none

`include "greedy_note_dispenser_top_defines.svh"

module greedy_note_dispenser_top #(
  parameter int MAX_DENOMS = gnd_pkg::DENOM_MAX
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // configuration write port
  input  wire logic                         cfg_we_i,
  input  wire logic [gnd_pkg::SLOT_W-1:0]   cfg_index_i,
  input  wire logic [gnd_pkg::AMOUNT_W-1:0] cfg_data_i,
  // amount in
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [gnd_pkg::AMOUNT_W-1:0] amount_i,
  // one result per slot out
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic      [gnd_pkg::SLOT_W-1:0]   slot_index_o,
  output logic      [gnd_pkg::AMOUNT_W-1:0] note_count_o,
  output logic      [gnd_pkg::AMOUNT_W-1:0] amount_left_o,
  output logic                              last_o
);

  gnd_pkg::gnd_state_e           state_q, state_d;
  logic [gnd_pkg::SLOT_W-1:0]    slot_q, slot_d;
  logic [gnd_pkg::AMOUNT_W-1:0]  left_q, left_d;
  logic [gnd_pkg::AMOUNT_W-1:0]  notes_q, notes_d;
  logic [gnd_pkg::SLOT_W-1:0]    used;
  logic [gnd_pkg::AMOUNT_W-1:0]  denom;
  logic [gnd_pkg::AMOUNT_W-1:0]  quot;
  logic [gnd_pkg::AMOUNT_W-1:0]  rem;
  gnd_pkg::gnd_div_stat_t        div_stat;
  logic                          div_start;
  logic                          in_xfer;
  logic                          out_xfer;

  // note table and slot count, read for the slot being worked on
  gnd_cfg_regs #(
    .MAX_DENOMS (MAX_DENOMS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .slot_i      (slot_q),
    .used_o      (used),
    .denom_o     (denom)
  );

  // the one shared divider: quotient is the note count, remainder the amount left
  gnd_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (left_q),
    .divisor_i  (denom),
    .stat_o     (div_stat),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;

  // sequencer: walk the slots from the highest in use down to slot 0
  always_comb begin
    state_d     = state_q;
    slot_d      = slot_q;
    left_d      = left_q;
    notes_d     = notes_q;
    div_start   = 1'b0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      gnd_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_xfer) begin
          left_d = amount_i;
          slot_d = used - 1'b1;
          // a slot count of zero gives no results at all
          if (used != '0) begin
            state_d = gnd_pkg::ST_START;
          end
        end
      end
      gnd_pkg::ST_START: begin
        if (denom == '0) begin
          // zero note value: nothing dispensed, amount carried through
          notes_d = '0;
          state_d = gnd_pkg::ST_EMIT;
        end else begin
          div_start = 1'b1;
          state_d   = gnd_pkg::ST_WAIT;
        end
      end
      gnd_pkg::ST_WAIT: begin
        if (div_stat.done) begin
          notes_d = quot;
          left_d  = rem;
          state_d = gnd_pkg::ST_EMIT;
        end
      end
      gnd_pkg::ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_xfer) begin
          if (slot_q == '0) begin
            state_d = gnd_pkg::ST_IDLE;
          end else begin
            slot_d  = slot_q - 1'b1;
            state_d = gnd_pkg::ST_START;
          end
        end
      end
      default: begin
        state_d = gnd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gnd_pkg::ST_IDLE;
      slot_q  <= '0;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
    end
  end

  // running amount doubles as the amount-left output register
  always_ff @(posedge clk_i) begin
    left_q  <= left_d;
    notes_q <= notes_d;
  end

  assign slot_index_o  = slot_q;
  assign note_count_o  = notes_q;
  assign amount_left_o = left_q;
  assign last_o        = (slot_q == '0);

  `GND_ASSERT_NOW(a_one_side_at_a_time, out_valid_o, !in_ready_o,
                  "input taken while a result is pending")
  `GND_ASSERT_NOW(a_done_only_when_waiting, div_stat.done, state_q == gnd_pkg::ST_WAIT,
                  "divider finished outside the wait state")
  `GND_ASSERT_NEXT(a_start_launches, in_xfer && (used != '0),
                   state_q == gnd_pkg::ST_START && slot_q == $past(used) - 1'b1,
                   "accepted amount did not start at the highest slot")
  `GND_ASSERT_NEXT(a_slot_steps_down, out_xfer && !last_o,
                   slot_q == $past(slot_q) - 1'b1 && state_q == gnd_pkg::ST_START,
                   "slot did not step down after a transfer")

endmodule

`default_nettype wire

// ===== tb/tb_greedy_note_dispenser_top.sv =====
`timescale 1ns / 1ps

module tb_greedy_note_dispenser_top;

  // widths and table depth as the block uses them
  localparam int AMOUNT_W  = gnd_pkg::AMOUNT_W;
  localparam int SLOT_W    = gnd_pkg::SLOT_W;
  localparam int DENOM_MAX = gnd_pkg::DENOM_MAX;

  // run length guards
  localparam int CYCLE_LIMIT      = 400000;
  // longer than one full seven-slot amount with every result stalled
  localparam int SETTLE_CYCLES    = 400;
  localparam int LONG_HOLD_CYCLES = 700;

  localparam logic [AMOUNT_W-1:0] AMOUNT_MAX = '1;

  // note table as the block holds it, slot 0 first
  typedef logic [AMOUNT_W-1:0] note_tab_t [DENOM_MAX];

  // one payout line: what a single slot hands out
  typedef struct packed {
    logic [SLOT_W-1:0]   slot;
    logic [AMOUNT_W-1:0] notes;
    logic [AMOUNT_W-1:0] left;
    logic                last;
  } payout_t;

  // shapes of random note tables
  typedef enum int {
    TAB_GEOMETRIC,
    TAB_SCALED,
    TAB_GAPPED,
    TAB_SCRAMBLED
  } tab_style_e;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [SLOT_W-1:0]   cfg_index_i = '0;
  logic [AMOUNT_W-1:0] cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic [AMOUNT_W-1:0] amount_i    = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [SLOT_W-1:0]   slot_index_o;
  logic [AMOUNT_W-1:0] note_count_o;
  logic [AMOUNT_W-1:0] amount_left_o;
  logic                last_o;

  // shadow copy of the dispenser registers
  logic [SLOT_W-1:0] slots_in_use;
  note_tab_t         note_values;

  payout_t expected_payouts[$];
  int      mismatches    = 0;
  bit      gaps_on       = 1'b1;
  bit      stalls_on     = 1'b1;
  bit      long_hold_req = 1'b0;

  greedy_note_dispenser_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .amount_i     (amount_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .slot_index_o (slot_index_o),
    .note_count_o (note_count_o),
    .amount_left_o(amount_left_o),
    .last_o       (last_o)
  );

  always #2 clk_i = ~clk_i;

  // greedy split of one amount over the slots in use, highest slot first
  function automatic void predict_payouts(input logic [AMOUNT_W-1:0] amount);
    logic [AMOUNT_W-1:0] left;
    int                  used;
    payout_t             p;
    left = amount;
    used = (slots_in_use > DENOM_MAX) ? DENOM_MAX : int'(slots_in_use);
    for (int s = used - 1; s >= 0; s--) begin
      p.slot = SLOT_W'(s);
      // a zero note value hands out nothing and leaves the amount alone
      if (note_values[s] != '0) begin
        p.notes = left / note_values[s];
        left    = left % note_values[s];
      end else begin
        p.notes = '0;
      end
      p.left = left;
      p.last = (s == 0);
      expected_payouts.push_back(p);
    end
  endfunction

  function automatic void flag_error(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
  endfunction

  // amounts biased towards the current table: multiples of the top note, small
  // change, full-width values and the two extremes
  function automatic logic [AMOUNT_W-1:0] pick_amount();
    logic [AMOUNT_W-1:0] top;
    logic [63:0]         prod;
    top = (slots_in_use == 0) ? AMOUNT_W'(1) : note_values[slots_in_use - 3'd1];
    prod = 64'(top) * 64'($urandom_range(0, 40)) + 64'($urandom_range(0, 3));
    case ($urandom_range(0, 7))
      0, 1:    return AMOUNT_W'($urandom);
      2:       return AMOUNT_W'($urandom_range(0, 1000));
      3, 4:    return prod[AMOUNT_W-1:0];
      5:       return ($urandom_range(0, 1) == 0) ? '0 : AMOUNT_MAX;
      default: return AMOUNT_W'($urandom) >> $urandom_range(0, 30);
    endcase
  endfunction

  // offer one amount; entered and left just after a rising edge
  task automatic offer_amount(input logic [AMOUNT_W-1:0] amount);
    int unsigned gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    amount_i   <= amount;
    do @(posedge clk_i); while (!in_ready_o);
    // transfer happened at this edge
    predict_payouts(amount);
  endtask

  // drop valid, let every pending payout arrive and give the block time to
  // finish an amount that produces no payout
  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (expected_payouts.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // write slot count and all seven note values while the block is idle
  task automatic load_table(input logic [SLOT_W-1:0] count, input note_tab_t tab);
    logic [AMOUNT_W-1:0] cfg_word;
    settle_block();
    // junk above the count field must be dropped by the block
    cfg_word              = AMOUNT_W'($urandom);
    cfg_word[SLOT_W-1:0]  = count;
    cfg_we_i    <= 1'b1;
    cfg_index_i <= gnd_pkg::CFG_DENOM_COUNT;
    cfg_data_i  <= cfg_word;
    @(posedge clk_i);
    slots_in_use = count;
    for (int s = 0; s < DENOM_MAX; s++) begin
      cfg_index_i <= SLOT_W'(gnd_pkg::CFG_DENOM_BASE + s);
      cfg_data_i  <= tab[s];
      @(posedge clk_i);
      note_values[s] = tab[s];
    end
    cfg_we_i <= 1'b0;
  endtask

  // reset table: one slot of value 1, so the whole amount comes out as notes
  task automatic test_reset_table();
    offer_amount('0);
    offer_amount(AMOUNT_MAX);
    offer_amount(AMOUNT_W'(12345));
  endtask

  task automatic test_directed_tables();
    note_tab_t tab;
    // everyday ascending table, all seven slots
    tab = '{31'd1, 31'd2, 31'd5, 31'd10, 31'd20, 31'd50, 31'd100};
    load_table(3'd7, tab);
    offer_amount('0);
    offer_amount(AMOUNT_W'(188));
    offer_amount(AMOUNT_W'(99));
    offer_amount(AMOUNT_MAX);
    // widest note values everywhere
    tab = '{default: AMOUNT_MAX};
    load_table(3'd7, tab);
    offer_amount(AMOUNT_MAX);
    offer_amount(AMOUNT_MAX - 1'b1);
    // zero note values scattered through the table
    tab = '{31'd0, 31'd3, 31'd0, 31'd7, 31'd0, 31'd0, 31'd25};
    load_table(3'd7, tab);
    offer_amount('0);
    offer_amount(AMOUNT_W'(100));
    offer_amount(AMOUNT_MAX);
    // single slot of zero value: nothing paid out, all left over
    tab = '{default: '0};
    load_table(3'd1, tab);
    offer_amount(AMOUNT_W'(9));
    // no slots in use: amounts are taken but give no payout
    tab = '{31'd1, 31'd2, 31'd5, 31'd10, 31'd20, 31'd50, 31'd100};
    load_table(3'd0, tab);
    offer_amount(AMOUNT_W'(5));
    offer_amount(AMOUNT_MAX);
    // descending table, still worked strictly from the top slot down
    tab = '{31'd100, 31'd50, 31'd20, 31'd10, 31'd5, 31'd2, 31'd1};
    load_table(3'd7, tab);
    offer_amount(AMOUNT_W'(188));
    offer_amount(AMOUNT_W'(7));
    // unused upper slots must not take part
    tab = '{31'd2, 31'd3, 31'd7, 31'd1, 31'd1, 31'd1, 31'd1};
    load_table(3'd3, tab);
    offer_amount(AMOUNT_W'(50));
    // note value 1 on the top slot swallows everything
    tab = '{31'd3, 31'd5, 31'd9, 31'd11, 31'd13, 31'd17, 31'd1};
    load_table(3'd7, tab);
    offer_amount(AMOUNT_MAX);
  endtask

  task automatic test_random_tables();
    note_tab_t         tab;
    logic [SLOT_W-1:0] count;
    for (int phase = 0; phase < 6; phase++) begin
      case (tab_style_e'(phase % 4))
        TAB_GEOMETRIC: begin
          tab[0] = AMOUNT_W'($urandom_range(1, 5));
          for (int s = 1; s < DENOM_MAX; s++)
            tab[s] = AMOUNT_W'(tab[s-1] * $urandom_range(2, 5));
        end
        TAB_SCALED: begin
          for (int s = 0; s < DENOM_MAX; s++)
            tab[s] = AMOUNT_W'($urandom) >> (4 * (DENOM_MAX - 1 - s));
        end
        TAB_GAPPED: begin
          tab[0] = AMOUNT_W'($urandom_range(1, 5));
          for (int s = 1; s < DENOM_MAX; s++)
            tab[s] = AMOUNT_W'(tab[s-1] * $urandom_range(2, 5));
          for (int s = 0; s < DENOM_MAX; s++) if ($urandom_range(0, 2) == 0) tab[s] = '0;
        end
        default: begin
          for (int s = 0; s < DENOM_MAX; s++)
            tab[s] = AMOUNT_W'($urandom) >> $urandom_range(0, 30);
        end
      endcase
      // extremes of the slot count first, then any count from 1 to 7
      if (phase == 0) count = 3'd7;
      else if (phase == 1) count = 3'd1;
      else count = SLOT_W'($urandom_range(1, 7));
      load_table(count, tab);
      repeat (18) offer_amount(pick_amount());
    end
  endtask

  // sink stops for a long stretch while amounts keep coming, so the block
  // fills and holds its input off
  task automatic test_output_backpressure();
    note_tab_t tab;
    tab = '{31'd1, 31'd2, 31'd5, 31'd10, 31'd20, 31'd50, 31'd100};
    load_table(3'd7, tab);
    gaps_on       = 1'b0;
    long_hold_req = 1'b1;
    repeat (6) offer_amount(pick_amount());
    gaps_on = 1'b1;
  endtask

  // closing stretch: no gaps and no stalls on either side
  task automatic test_unbroken_stream();
    note_tab_t tab;
    for (int s = 0; s < DENOM_MAX; s++)
      tab[s] = AMOUNT_W'($urandom) >> (4 * (DENOM_MAX - 1 - s));
    load_table(3'd7, tab);
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    repeat (20) offer_amount(pick_amount());
  endtask

  // sink side: ready in random bursts, plus the one long hold on request
  initial begin : sink_ready
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
      end else if (stalls_on && $urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  // every payout transfer is matched against the oldest expectation
  always @(posedge clk_i) begin : payout_check
    payout_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_payouts.size() == 0) begin
        flag_error($sformatf("unexpected payout: slot %0d notes %0d left %0d last %0b",
                             slot_index_o, note_count_o, amount_left_o, last_o));
      end else begin
        want = expected_payouts.pop_front();
        if (want.slot !== slot_index_o || want.notes !== note_count_o ||
            want.left !== amount_left_o || want.last !== last_o) begin
          flag_error($sformatf({"payout mismatch: exp slot %0d notes %0d left %0d last %0b",
                                " / got slot %0d notes %0d left %0d last %0b"},
                               want.slot, want.notes, want.left, want.last,
                               slot_index_o, note_count_o, amount_left_o, last_o));
        end
      end
    end
  end

  // hard stop should the block hang
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : run_tests
    // register state right after reset
    slots_in_use   = 3'd1;
    note_values    = '{default: '0};
    note_values[0] = AMOUNT_W'(1);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_table();
    test_directed_tables();
    test_random_tables();
    test_output_backpressure();
    test_unbroken_stream();

    // drain and give any stray payout time to show up
    settle_block();
    if (mismatches == 0 && expected_payouts.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
